@@ rtl/core/ipv6urf_pkg.sv @@
// Package for the IPv6 UDP receive filter.
// Holds sizes, verdict codes, result structs and address byte functions.
// No dependencies.
`default_nettype none
package ipv6urf_pkg;

	localparam int RING_DEPTH = 2048;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int MAX_FRAME  = 2048;
	localparam int POS_W      = $clog2(MAX_FRAME + 1);

	localparam logic [15:0] ETH_TYPE_V6 = 16'h86DD;
	localparam logic [7:0]  NH_UDP      = 8'd17;
	localparam logic [7:0]  NH_ICMP6    = 8'd58;
	localparam logic [7:0]  ICMP_NSOL   = 8'd135;

	// Frame byte offsets
	localparam int OFS_ETH_HI  = 12;
	localparam int OFS_ETH_LO  = 13;
	localparam int OFS_NH      = 20;
	localparam int OFS_DST     = 38;
	localparam int OFS_L4      = 54;
	localparam int OFS_UDP_PL  = 62;
	localparam int OFS_TGT_END = 78;

	// Configuration register indexes
	localparam logic [1:0] REG_OWN_MAC      = 2'd0;
	localparam logic [1:0] REG_LISTEN_PORT  = 2'd1;
	localparam logic [1:0] REG_FIXED_SUFFIX = 2'd2;

	localparam logic [15:0] FIXED_SUFFIX_RST = 16'h4919;

	typedef enum logic [2:0] {
		V_ACCEPTED = 3'd0,
		V_FOREIGN  = 3'd1,
		V_DROPPED  = 3'd2,
		V_SOL_DER  = 3'd3,
		V_SOL_FIX  = 3'd4,
		V_IGNORED  = 3'd5
	} verdict_t;

	// Speculative payload write request from the parser
	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] ofs;
		logic [7:0]         data;
	} stage_wr_t;

	// Frame verdict from the parser, valid with the last byte
	typedef struct packed {
		logic               done;
		verdict_t           verdict;
		logic               commit;
		logic [RING_AW-1:0] plen;
		logic [15:0]        sport;
	} frame_res_t;

	// EUI-64 link-local address byte derived from the MAC
	function automatic logic [7:0] derived_byte(input logic [47:0] mac, input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:  r = 8'hfe;
			4'd1:  r = 8'h80;
			4'd8:  r = mac[47:40] ^ 8'h02;
			4'd9:  r = mac[39:32];
			4'd10: r = mac[31:24];
			4'd11: r = 8'hff;
			4'd12: r = 8'hfe;
			4'd13: r = mac[23:16];
			4'd14: r = mac[15:8];
			4'd15: r = mac[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Fixed link-local address fe80::suffix
	function automatic logic [7:0] fixed_byte(input logic [15:0] sfx, input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0:  r = 8'hfe;
			4'd1:  r = 8'h80;
			4'd14: r = sfx[15:8];
			4'd15: r = sfx[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/ipv6urf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ipv6urf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port; read data holds when no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ipv6urf_parse.sv @@
// Frame parser: tracks byte position, header fields and mismatch flags,
// issues speculative payload writes and classifies at the last byte.
// Depends on ipv6urf_pkg.
`default_nettype none
module ipv6urf_parse (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               take,
	input  wire [7:0]                         data_byte,
	input  wire                               last_byte,
	input  wire [47:0]                        own_mac,
	input  wire [15:0]                        listen_port,
	input  wire [15:0]                        fixed_suffix,
	input  wire [ipv6urf_pkg::RING_AW-1:0]    ring_free,
	output ipv6urf_pkg::stage_wr_t            wr,
	output ipv6urf_pkg::frame_res_t           res
);

	logic [ipv6urf_pkg::POS_W-1:0] pos_q, pos_n, len_n;
	logic [15:0] dport_q, dport_n, ulen_q, ulen_n, sport_q, sport_n;
	logic [7:0]  nh_q, nh_n, itype_q, itype_n;
	logic mis_eth_q, mis_eth_n, mis_dd_q, mis_dd_n, mis_df_q, mis_df_n;
	logic mis_td_q, mis_td_n, mis_tf_q, mis_tf_n, spill_q, spill_n;
	logic [ipv6urf_pkg::POS_W-1:0] p;
	logic [ipv6urf_pkg::POS_W-1:0] pd, pt, pk;
	logic [16:0] k_ext;
	logic [16:0] len_ext;
	logic [15:0] payload;
	logic        in_range;

	// Next header state for this byte
	always_comb begin
		p = pos_q;
		in_range = (pos_q < ipv6urf_pkg::POS_W'(ipv6urf_pkg::MAX_FRAME));
		pd = p - ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_DST);
		pt = p - ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_UDP_PL);
		pk = pt;
		k_ext = {{(17 - ipv6urf_pkg::POS_W){1'b0}}, pk};
		dport_n = dport_q; ulen_n = ulen_q; sport_n = sport_q;
		nh_n = nh_q; itype_n = itype_q;
		mis_eth_n = mis_eth_q; mis_dd_n = mis_dd_q; mis_df_n = mis_df_q;
		mis_td_n = mis_td_q; mis_tf_n = mis_tf_q; spill_n = spill_q;
		wr.en = 1'b0;
		wr.ofs = pk[ipv6urf_pkg::RING_AW-1:0];
		wr.data = data_byte;
		len_n = pos_q;
		if (take && in_range) begin
			len_n = pos_q + 1'b1;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_ETH_HI) &&
			    data_byte != ipv6urf_pkg::ETH_TYPE_V6[15:8]) mis_eth_n = 1'b1;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_ETH_LO) &&
			    data_byte != ipv6urf_pkg::ETH_TYPE_V6[7:0]) mis_eth_n = 1'b1;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_NH)) nh_n = data_byte;
			if (p >= ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_DST) &&
			    p < ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4)) begin
				if (data_byte != ipv6urf_pkg::derived_byte(own_mac, pd[3:0])) mis_dd_n = 1'b1;
				if (data_byte != ipv6urf_pkg::fixed_byte(fixed_suffix, pd[3:0])) mis_df_n = 1'b1;
			end
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4)) begin
				sport_n[15:8] = data_byte;
				itype_n = data_byte;
			end
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4 + 1)) sport_n[7:0] = data_byte;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4 + 2)) dport_n[15:8] = data_byte;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4 + 3)) dport_n[7:0] = data_byte;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4 + 4)) ulen_n[15:8] = data_byte;
			if (p == ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_L4 + 5)) ulen_n[7:0] = data_byte;
			if (p >= ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_UDP_PL) &&
			    p < ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_TGT_END)) begin
				if (data_byte != ipv6urf_pkg::derived_byte(own_mac, pt[3:0])) mis_td_n = 1'b1;
				if (data_byte != ipv6urf_pkg::fixed_byte(fixed_suffix, pt[3:0])) mis_tf_n = 1'b1;
			end
			// Speculative payload store past the UDP header
			if (p >= ipv6urf_pkg::POS_W'(ipv6urf_pkg::OFS_UDP_PL) &&
			    nh_n == ipv6urf_pkg::NH_UDP &&
			    (k_ext + 17'd8) < {1'b0, ulen_n}) begin
				if (k_ext < {{(17 - ipv6urf_pkg::RING_AW){1'b0}}, ring_free}) begin
					wr.en = 1'b1;
				end else begin
					spill_n = 1'b1;
				end
			end
		end
	end

	// Classification on the updated header state
	always_comb begin
		len_ext = {{(17 - ipv6urf_pkg::POS_W){1'b0}}, len_n};
		payload = ulen_n - 16'd8;
		res.done = take && last_byte;
		res.commit = 1'b0;
		res.plen = payload[ipv6urf_pkg::RING_AW-1:0];
		res.sport = sport_n;
		res.verdict = ipv6urf_pkg::V_FOREIGN;
		if (len_ext < 17'(ipv6urf_pkg::OFS_L4)) begin
			res.verdict = ipv6urf_pkg::V_IGNORED;
		end else if (mis_eth_n) begin
			res.verdict = ipv6urf_pkg::V_FOREIGN;
		end else if (nh_n == ipv6urf_pkg::NH_ICMP6) begin
			if (len_ext < 17'(ipv6urf_pkg::OFS_TGT_END) || itype_n != ipv6urf_pkg::ICMP_NSOL)
				res.verdict = ipv6urf_pkg::V_IGNORED;
			else if (!mis_td_n) res.verdict = ipv6urf_pkg::V_SOL_DER;
			else if (!mis_tf_n) res.verdict = ipv6urf_pkg::V_SOL_FIX;
			else res.verdict = ipv6urf_pkg::V_IGNORED;
		end else if (nh_n == ipv6urf_pkg::NH_UDP) begin
			if (len_ext < 17'(ipv6urf_pkg::OFS_UDP_PL)) res.verdict = ipv6urf_pkg::V_IGNORED;
			else if (dport_n != listen_port) res.verdict = ipv6urf_pkg::V_FOREIGN;
			else if (ulen_n < 16'd8 ||
			         (17'(ipv6urf_pkg::OFS_L4) + {1'b0, ulen_n}) > len_ext)
				res.verdict = ipv6urf_pkg::V_DROPPED;
			else if (payload > {{(16 - ipv6urf_pkg::RING_AW){1'b0}}, ring_free})
				res.verdict = ipv6urf_pkg::V_DROPPED;
			else if (mis_dd_n && mis_df_n) res.verdict = ipv6urf_pkg::V_FOREIGN;
			else if (spill_n) res.verdict = ipv6urf_pkg::V_DROPPED;
			else begin
				res.verdict = ipv6urf_pkg::V_ACCEPTED;
				res.commit = 1'b1;
			end
		end
		if (!res.done) res.commit = 1'b0;
	end

	// Header state; cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; dport_q <= '0; ulen_q <= '0; sport_q <= '0;
			nh_q <= '0; itype_q <= '0;
			mis_eth_q <= 1'b0; mis_dd_q <= 1'b0; mis_df_q <= 1'b0;
			mis_td_q <= 1'b0; mis_tf_q <= 1'b0; spill_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				pos_q <= '0; dport_q <= '0; ulen_q <= '0; sport_q <= '0;
				nh_q <= '0; itype_q <= '0;
				mis_eth_q <= 1'b0; mis_dd_q <= 1'b0; mis_df_q <= 1'b0;
				mis_td_q <= 1'b0; mis_tf_q <= 1'b0; spill_q <= 1'b0;
			end else begin
				pos_q <= len_n; dport_q <= dport_n; ulen_q <= ulen_n;
				sport_q <= sport_n; nh_q <= nh_n; itype_q <= itype_n;
				mis_eth_q <= mis_eth_n; mis_dd_q <= mis_dd_n; mis_df_q <= mis_df_n;
				mis_td_q <= mis_td_n; mis_tf_q <= mis_tf_n; spill_q <= spill_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ipv6_udp_receive_filter.sv @@
// Top level of the IPv6 UDP receive filter: ring pointers, read path,
// result pipeline. Depends on ipv6urf_pkg, ipv6urf_parse, ipv6urf_ram.
//
//   port group   direction  handshake              contents
//   in           in         in_valid / in_ready    cmd, data_byte, last_byte
//   out          out        out_valid / out_ready  kind ... peer_seen
//   cfg          in         cfg_we                 cfg_index, cfg_data
//
// One request per cycle while in_ready is high. A frame byte updates the
// parser and writes the ring in its accept cycle; a ring read starts the RAM
// read in its accept cycle. A result enters the result stage at its accept
// edge and moves on to the output register. The output register decouples the
// sides; in_ready drops only when both are full and out_ready is low. Reset
// clears pointers and parser state; the ring is not cleared.
`default_nettype none
module ipv6_udp_receive_filter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [47:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         cmd,
	input  wire [7:0]   data_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        kind,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic [2:0]  verdict,
	output logic [10:0] commit_len,
	output logic [15:0] remote_port,
	output logic        peer_seen
);

	logic [47:0] own_mac_q;
	logic [15:0] listen_port_q, fixed_suffix_q;
	logic [ipv6urf_pkg::RING_AW-1:0] whead_q, rtail_q, used, free;
	logic [15:0] lport_q;
	logic        known_q;
	logic        acc, take, rd, nonempty;
	ipv6urf_pkg::stage_wr_t  wr;
	ipv6urf_pkg::frame_res_t fres;
	logic [7:0]  ram_q;

	// result stage
	logic        v_s1, kind_s1, rv_s1;
	logic [2:0]  verd_s1;
	logic [ipv6urf_pkg::RING_AW-1:0] plen_s1;
	logic [15:0] port_s1;
	logic        known_s1, adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			listen_port_q <= '0;
			fixed_suffix_q <= ipv6urf_pkg::FIXED_SUFFIX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ipv6urf_pkg::REG_OWN_MAC:      own_mac_q <= cfg_data;
				ipv6urf_pkg::REG_LISTEN_PORT:  listen_port_q <= cfg_data[15:0];
				ipv6urf_pkg::REG_FIXED_SUFFIX: fixed_suffix_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv;
	assign acc      = in_valid && in_ready;
	assign take     = acc && !cmd;
	assign rd       = acc && cmd;
	assign used     = whead_q - rtail_q;
	assign free     = ipv6urf_pkg::RING_AW'(ipv6urf_pkg::RING_DEPTH - 1) - used;
	assign nonempty = (rtail_q != whead_q);

	ipv6urf_parse u_parse (
		.clk(clk), .arst_n(arst_n), .take(take),
		.data_byte(data_byte), .last_byte(last_byte),
		.own_mac(own_mac_q), .listen_port(listen_port_q),
		.fixed_suffix(fixed_suffix_q), .ring_free(free),
		.wr(wr), .res(fres)
	);

	ipv6urf_ram #(.WIDTH(8), .DEPTH(ipv6urf_pkg::RING_DEPTH)) u_ring (
		.clk(clk), .we(wr.en), .waddr(whead_q + wr.ofs), .wdata(wr.data),
		.re(rd && nonempty), .raddr(rtail_q), .rdata(ram_q)
	);

	// Ring pointers and learned peer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whead_q <= '0;
			rtail_q <= '0;
			lport_q <= '0;
			known_q <= 1'b0;
		end else begin
			if (rd && nonempty) rtail_q <= rtail_q + 1'b1;
			if (fres.commit) begin
				whead_q <= whead_q + fres.plen;
				lport_q <= fres.sport;
				known_q <= 1'b1;
			end
		end
	end

	// Result stage: waits on the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rd || fres.done) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd || fres.done) begin
			kind_s1  <= !rd;
			rv_s1    <= rd && nonempty;
			verd_s1  <= rd ? ipv6urf_pkg::V_ACCEPTED : fres.verdict;
			plen_s1  <= fres.commit ? fres.plen : '0;
			port_s1  <= fres.commit ? fres.sport : lport_q;
			known_s1 <= fres.commit || known_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			kind        <= kind_s1;
			read_valid  <= rv_s1;
			read_data   <= rv_s1 ? ram_q : 8'h00;
			verdict     <= verd_s1;
			commit_len  <= 11'(plen_s1);
			remote_port <= port_s1;
			peer_seen   <= known_s1;
		end
	end

endmodule
`default_nettype wire

@@ verif/ipv6_udp_receive_filter_tb.sv @@
// Self-checking testbench for ipv6_udp_receive_filter: builds IPv6 frames and ring
// reads, predicts verdicts and popped bytes, and checks every result in order.
// Depends on ipv6urf_pkg and the filter RTL.
`timescale 1ns / 1ps

module ipv6_udp_receive_filter_tb;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
		logic       last;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rd;
		logic       rv;
		logic [2:0] vd;
		logic [10:0] plen;
		logic [15:0] port;
		logic       hp;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = ipv6urf_pkg::REG_OWN_MAC;
	logic [47:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t cur = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind, read_valid, peer_seen;
	logic [7:0] read_data;
	logic [2:0] verdict;
	logic [10:0] commit_len;
	logic [15:0] remote_port;

	ipv6_udp_receive_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cur.cmd), .data_byte(cur.data), .last_byte(cur.last),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .read_data(read_data), .read_valid(read_valid),
		.verdict(verdict), .commit_len(commit_len),
		.remote_port(remote_port), .peer_seen(peer_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	req_t pending[$];
	res_t expected_res[$];
	int send_idle = 11;
	int recv_idle = 88;
	int mismatches = 0;
	int n_items = 0;

	// Predictor state
	logic [47:0] m_mac = '0;
	logic [15:0] m_lport = '0;
	logic [15:0] m_sfx = ipv6urf_pkg::FIXED_SUFFIX_RST;
	logic [7:0] ring [ipv6urf_pkg::RING_DEPTH];
	int whead = 0, rtail = 0, fpos = 0;
	logic [7:0] nh = '0, itype = '0;
	logic [15:0] sport = '0, dport = '0, ulen = '0;
	logic bad_eth = 0, nd_der = 0, nd_fix = 0, nt_der = 0, nt_fix = 0, spill = 0;
	logic [15:0] peer = '0;
	logic known = 1'b0;

	function automatic logic [7:0] eui_byte(int i);
		case (i)
			0: return 8'hfe;
			1: return 8'h80;
			8: return m_mac[47:40] ^ 8'h02;
			9: return m_mac[39:32];
			10: return m_mac[31:24];
			11: return 8'hff;
			12: return 8'hfe;
			13: return m_mac[23:16];
			14: return m_mac[15:8];
			15: return m_mac[7:0];
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] fix_byte(int i);
		case (i)
			0: return 8'hfe;
			1: return 8'h80;
			14: return m_sfx[15:8];
			15: return m_sfx[7:0];
			default: return 8'h00;
		endcase
	endfunction

	function automatic int ring_fill();
		return (whead + ipv6urf_pkg::RING_DEPTH - rtail) % ipv6urf_pkg::RING_DEPTH;
	endfunction

	function automatic int ring_free();
		return ipv6urf_pkg::RING_DEPTH - 1 - ring_fill();
	endfunction

	// Per-byte header capture, address compares and speculative payload store
	function automatic void absorb(int p, logic [7:0] b);
		int k;
		if (p == ipv6urf_pkg::OFS_ETH_HI && b != ipv6urf_pkg::ETH_TYPE_V6[15:8]) bad_eth = 1;
		if (p == ipv6urf_pkg::OFS_ETH_LO && b != ipv6urf_pkg::ETH_TYPE_V6[7:0]) bad_eth = 1;
		if (p == ipv6urf_pkg::OFS_NH) nh = b;
		if (p >= ipv6urf_pkg::OFS_DST && p < ipv6urf_pkg::OFS_L4) begin
			if (b != eui_byte(p - ipv6urf_pkg::OFS_DST)) nd_der = 1;
			if (b != fix_byte(p - ipv6urf_pkg::OFS_DST)) nd_fix = 1;
		end
		if (p == 54) begin
			sport[15:8] = b;
			itype = b;
		end
		if (p == 55) sport[7:0] = b;
		if (p == 56) dport[15:8] = b;
		if (p == 57) dport[7:0] = b;
		if (p == 58) ulen[15:8] = b;
		if (p == 59) ulen[7:0] = b;
		if (p >= ipv6urf_pkg::OFS_UDP_PL && p < ipv6urf_pkg::OFS_TGT_END) begin
			if (b != eui_byte(p - ipv6urf_pkg::OFS_UDP_PL)) nt_der = 1;
			if (b != fix_byte(p - ipv6urf_pkg::OFS_UDP_PL)) nt_fix = 1;
		end
		if (p >= ipv6urf_pkg::OFS_UDP_PL && nh == ipv6urf_pkg::NH_UDP) begin
			k = p - ipv6urf_pkg::OFS_UDP_PL;
			if (k + 8 < int'(ulen)) begin
				if (k < ring_free()) ring[(whead + k) % ipv6urf_pkg::RING_DEPTH] = b;
				else spill = 1;
			end
		end
	endfunction

	function automatic ipv6urf_pkg::verdict_t classify(int len, output int pl);
		pl = 0;
		if (len < 54) return ipv6urf_pkg::V_IGNORED;
		if (bad_eth) return ipv6urf_pkg::V_FOREIGN;
		if (nh == ipv6urf_pkg::NH_ICMP6) begin
			if (len < 78 || itype != ipv6urf_pkg::ICMP_NSOL) return ipv6urf_pkg::V_IGNORED;
			if (!nt_der) return ipv6urf_pkg::V_SOL_DER;
			if (!nt_fix) return ipv6urf_pkg::V_SOL_FIX;
			return ipv6urf_pkg::V_IGNORED;
		end
		if (nh == ipv6urf_pkg::NH_UDP) begin
			if (len < 62) return ipv6urf_pkg::V_IGNORED;
			if (dport != m_lport) return ipv6urf_pkg::V_FOREIGN;
			if (ulen < 8 || 54 + int'(ulen) > len) return ipv6urf_pkg::V_DROPPED;
			if (int'(ulen) - 8 > ring_free()) return ipv6urf_pkg::V_DROPPED;
			if (nd_der && nd_fix) return ipv6urf_pkg::V_FOREIGN;
			if (spill) return ipv6urf_pkg::V_DROPPED;
			peer = sport;
			known = 1'b1;
			pl = int'(ulen) - 8;
			whead = (whead + pl) % ipv6urf_pkg::RING_DEPTH;
			return ipv6urf_pkg::V_ACCEPTED;
		end
		return ipv6urf_pkg::V_FOREIGN;
	endfunction

	// Expected result of one accepted request, if any
	function automatic void predict(req_t r);
		res_t e;
		int pl;
		e = '0;
		if (r.cmd) begin
			if (rtail != whead) begin
				e.rd = ring[rtail];
				e.rv = 1'b1;
				rtail = (rtail + 1) % ipv6urf_pkg::RING_DEPTH;
			end
		end else begin
			if (fpos < ipv6urf_pkg::MAX_FRAME) begin
				absorb(fpos, r.data);
				fpos++;
			end
			if (!r.last) return;
			e.kind = 1'b1;
			e.vd = classify(fpos, pl);
			e.plen = pl[10:0];
			fpos = 0;
			nh = '0; itype = '0; sport = '0; dport = '0; ulen = '0;
			{bad_eth, nd_der, nd_fix, nt_der, nt_fix, spill} = '0;
		end
		e.port = peer;
		e.hp = known;
		expected_res.push_back(e);
	endfunction

	// Request driver
	always @(posedge clk) begin
		logic nv;
		nv = in_valid;
		if (in_valid && in_ready) begin
			predict(cur);
			nv = 1'b0;
		end
		if (!nv && arst_n && pending.size() != 0 && $urandom_range(99) >= send_idle) begin
			cur <= pending.pop_front();
			nv = 1'b1;
		end
		in_valid <= nv;
	end

	// Result monitor
	always @(posedge clk) begin
		res_t g, w;
		if (out_valid && out_ready) begin
			g = '{kind, read_data, read_valid, verdict, commit_len, remote_port, peer_seen};
			if (expected_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", g);
			end else begin
				w = expected_res.pop_front();
				if (g.kind !== w.kind || g.rd !== w.rd || g.rv !== w.rv || g.vd !== w.vd
						|| g.plen !== w.plen || g.port !== w.port || g.hp !== w.hp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", w, g);
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// Stimulus helpers
	task automatic put_reads(int n);
		req_t r;
		repeat (n) begin
			r = '{1'b1, 8'($urandom), 1'($urandom)};
			pending.push_back(r);
			n_items++;
		end
	endtask

	task automatic emit(logic [7:0] frm[$], int rd_pct);
		req_t r;
		foreach (frm[i]) begin
			if ($urandom_range(99) < rd_pct) put_reads(1);
			r = '{1'b0, frm[i], i == frm.size() - 1};
			pending.push_back(r);
			n_items++;
		end
	endtask

	function automatic logic [7:0] addr_byte(int sel, int i);
		if (sel == 0) return eui_byte(i);
		if (sel == 1) return fix_byte(i);
		return 8'($urandom);
	endfunction

	// Ethernet + IPv6 header up to and including the destination address
	function automatic void ip_head(ref logic [7:0] frm[$], input logic [7:0] nxt,
			input int asel);
		frm.delete();
		repeat (12) frm.push_back(8'($urandom));
		frm.push_back(ipv6urf_pkg::ETH_TYPE_V6[15:8]);
		frm.push_back(ipv6urf_pkg::ETH_TYPE_V6[7:0]);
		frm.push_back(8'h60);
		repeat (5) frm.push_back(8'($urandom));
		frm.push_back(nxt);
		repeat (17) frm.push_back(8'($urandom));
		for (int i = 0; i < 16; i++) frm.push_back(addr_byte(asel, i));
	endfunction

	function automatic void udp_frame(ref logic [7:0] frm[$], input int asel,
			input logic [15:0] port, input int plen, input int pad);
		logic [15:0] ul;
		ul = 16'(plen + 8);
		ip_head(frm, ipv6urf_pkg::NH_UDP, asel);
		frm.push_back(8'($urandom));
		frm.push_back(8'($urandom));
		frm.push_back(port[15:8]);
		frm.push_back(port[7:0]);
		frm.push_back(ul[15:8]);
		frm.push_back(ul[7:0]);
		repeat (2 + plen + pad) frm.push_back(8'($urandom));
	endfunction

	function automatic void icmp_frame(ref logic [7:0] frm[$], input int tsel,
			input logic [7:0] ty, input int pad);
		ip_head(frm, ipv6urf_pkg::NH_ICMP6, $urandom_range(2));
		frm.push_back(ty);
		repeat (7) frm.push_back(8'($urandom));
		for (int i = 0; i < 16; i++) frm.push_back(addr_byte(tsel, i));
		repeat (pad) frm.push_back(8'($urandom));
	endfunction

	// At least one frame of each frame class and verdict
	task automatic directed_frames();
		logic [7:0] f[$];
		put_reads(2);
		udp_frame(f, 0, m_lport, 5, 0); emit(f, 0);
		udp_frame(f, 1, m_lport, 0, 3); emit(f, 0);
		udp_frame(f, 2, m_lport, 4, 0); emit(f, 0);
		udp_frame(f, 0, ~m_lport, 4, 0); emit(f, 0);
		udp_frame(f, 0, m_lport, 4, 0); f[58] = 8'h00; f[59] = 8'h05; emit(f, 0);
		udp_frame(f, 1, m_lport, 4, 0); f[59] = 8'hf0; emit(f, 0);
		udp_frame(f, 0, m_lport, 4, 0); f[13] = 8'h00; emit(f, 0);
		udp_frame(f, 0, m_lport, 4, 0); f[20] = 8'd6; emit(f, 0);
		udp_frame(f, 0, m_lport, 0, 0); f = f[0:60]; emit(f, 0);
		udp_frame(f, 0, m_lport, 0, 0); f = f[0:52]; emit(f, 0);
		f = '{8'hff}; emit(f, 0);
		icmp_frame(f, 0, ipv6urf_pkg::ICMP_NSOL, 0); emit(f, 0);
		icmp_frame(f, 1, ipv6urf_pkg::ICMP_NSOL, 2); emit(f, 0);
		icmp_frame(f, 2, ipv6urf_pkg::ICMP_NSOL, 0); emit(f, 0);
		icmp_frame(f, 0, 8'd136, 0); emit(f, 0);
		icmp_frame(f, 0, ipv6urf_pkg::ICMP_NSOL, 0); f.pop_back(); emit(f, 0);
		put_reads(12);
	endtask

	task automatic random_traffic(int budget);
		logic [7:0] f[$];
		int stop, sel, a, n;
		stop = n_items + budget;
		while (n_items < stop) begin
			sel = $urandom_range(99);
			a = $urandom_range(99);
			a = a < 45 ? 0 : (a < 90 ? 1 : 2);
			if (sel < 60) begin
				udp_frame(f, a, ($urandom_range(9) == 0) ? 16'($urandom) : m_lport,
					($urandom_range(3) == 0) ? $urandom_range(120) : $urandom_range(16),
					($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
			end else if (sel < 72) begin
				icmp_frame(f, a,
					($urandom_range(4) == 0) ? 8'($urandom) : ipv6urf_pkg::ICMP_NSOL,
					$urandom_range(3));
			end else if (sel < 88) begin
				f.delete();
				repeat ($urandom_range(1, 90)) f.push_back(8'($urandom));
			end
			if (sel < 88) begin
				// break a header byte or cut the frame short now and then
				if ($urandom_range(6) == 0) begin
					n = $urandom_range(12, 61);
					if (n < f.size()) f[n] = f[n] ^ (8'h01 << $urandom_range(7));
				end else if ($urandom_range(8) == 0) begin
					f = f[0:$urandom_range(f.size() - 1)];
				end
				emit(f, ($urandom_range(2) == 0) ? 8 : 0);
			end else begin
				put_reads($urandom_range(1, 20));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || in_valid || expected_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ipv6urf_pkg::REG_OWN_MAC: m_mac = val;
			ipv6urf_pkg::REG_LISTEN_PORT: m_lport = val[15:0];
			ipv6urf_pkg::REG_FIXED_SUFFIX: m_sfx = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [47:0] mac, logic [15:0] port, logic [15:0] sfx);
		write_reg(ipv6urf_pkg::REG_OWN_MAC, mac);
		write_reg(ipv6urf_pkg::REG_LISTEN_PORT, {32'h0, port});
		write_reg(ipv6urf_pkg::REG_FIXED_SUFFIX, {32'h0, sfx});
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset configuration, sender lightly idle, receiver mostly stalled
		directed_frames();
		random_traffic(150);
		wait_drained();

		send_idle = 88;
		recv_idle = 11;
		set_config({16'($urandom), 32'($urandom)}, 16'($urandom), 16'($urandom));
		random_traffic(300);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		set_config(48'hffff_ffff_ffff, 16'hffff, 16'h0000);
		random_traffic(300);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
